// File: rtl/lavm_pkg.sv
// shared types and constants of the look-at view matrix unit
`timescale 1ns / 1ps
package lavm_pkg;

   typedef logic signed [17:0] s18_type;
   typedef logic signed [18:0] s19_type;
   typedef logic signed [23:0] s24_type;
   typedef logic signed [31:0] s32_type;
   typedef logic signed [37:0] s38_type;
   typedef logic signed [55:0] s56_type;
   typedef logic signed [57:0] s58_type;

   localparam s32_type    ONE_Q16  = 32'sd65536;
   localparam logic [1:0] ROW_LAST = 2'd3;

   typedef struct packed {
      s32_type pos_x;
      s32_type pos_y;
      s32_type pos_z;
      s32_type fwd_x;
      s32_type fwd_y;
      s32_type fwd_z;
      s32_type up_x;
      s32_type up_y;
      s32_type up_z;
   } req_type;

   typedef struct packed {
      logic [1:0] row_index;
      s32_type    col0;
      s32_type    col1;
      s32_type    col2;
      s32_type    col3;
      logic       last_row;
      logic       degenerate;
   } rsp_type;

endpackage

// File: rtl/look_at_view_matrix_unit.sv
// look-at view matrix unit: normalise, cross products, dot terms, row output
`timescale 1ns / 1ps
// a request passes the stage registers and the output register before its first row
// one matrix in the output register at a time, sent as four response beats per request
// the pipeline takes a request every cycle while its last stage is empty or can move on
// reset: synchronous, clears stage valid bits, output valid and row counter, no sweep
module look_at_view_matrix_unit
   import lavm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ST_SH   = 1;
   localparam int ST_SFT  = 2;
   localparam int ST_SQ   = 3;
   localparam int ST_SUM  = 4;
   localparam int ST_RT0  = 5;
   localparam int RT_N    = 16;
   localparam int ST_DIV0 = ST_RT0 + RT_N;
   localparam int ST_DB0  = ST_DIV0 + 1;
   localparam int DB_N    = 17;
   localparam int ST_SGN  = ST_DB0 + DB_N;
   localparam int ST_FU   = ST_SGN + 1;
   localparam int ST_S    = ST_SGN + 2;
   localparam int ST_SF   = ST_SGN + 3;
   localparam int ST_T    = ST_SGN + 4;
   localparam int ST_TP   = ST_SGN + 5;
   localparam int ST_TS   = ST_SGN + 6;
   localparam int ST_TC   = ST_SGN + 7;
   localparam int NST     = ST_TC + 1;

   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic             zero;
      logic [4:0]       sh;
      logic [2:0][63:0] sq;
      logic [63:0]      rad;
      logic [35:0]      srem;
      logic [31:0]      root;
      logic [2:0][47:0] num;
      logic [2:0][32:0] drem;
      logic [2:0][16:0] quo;
   } vec_type;

   typedef struct packed {
      vec_type                fv;
      vec_type                uv;
      s32_type [2:0]          pos;
      s18_type [2:0]          f;
      s18_type [2:0]          u;
      s19_type [2:0]          s;
      s24_type [2:0]          t;
      s38_type [5:0]          pr;
      logic [2:0][2:0][55:0]  dp;
      s58_type [2:0]          ds;
      s32_type [2:0]          c3;
      logic                   degen;
   } pipe_type;

   function automatic logic signed [63:0] rdiv16(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + 64'd32768) >> 16;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic s32_type sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return s32_type'(v);
   endfunction

   function automatic vec_type vec_front(input s32_type a, input s32_type b, input s32_type c);
      vec_type r;
      r = '0;
      r.neg[0] = a[31];
      r.neg[1] = b[31];
      r.neg[2] = c[31];
      r.mag[0] = a[31] ? 32'(-a) : 32'(a);
      r.mag[1] = b[31] ? 32'(-b) : 32'(b);
      r.mag[2] = c[31] ? 32'(-c) : 32'(c);
      r.zero = (a == '0) && (b == '0) && (c == '0);
      return r;
   endfunction

   function automatic vec_type norm_next(input vec_type v, input int k);
      vec_type     r;
      logic [31:0] mx;
      logic [4:0]  lz;
      logic [35:0] rm;
      logic [35:0] trial;
      logic [31:0] rt;
      logic [63:0] rd;
      logic [32:0] tr;
      int          b;
      r = v;
      if (k == ST_SH) begin
         mx = v.mag[0];
         if (v.mag[1] > mx) mx = v.mag[1];
         if (v.mag[2] > mx) mx = v.mag[2];
         lz = '0;
         for (int i = 0; i < 32; i++) begin
            if (mx[i]) lz = 5'(31 - i);
         end
         r.sh = (lz >= 5'd2) ? lz - 5'd1 : 5'd0;
      end else if (k == ST_SFT) begin
         for (int i = 0; i < 3; i++) r.mag[i] = v.mag[i] << v.sh;
      end else if (k == ST_SQ) begin
         for (int i = 0; i < 3; i++) r.sq[i] = 64'(v.mag[i]) * 64'(v.mag[i]);
      end else if (k == ST_SUM) begin
         r.rad  = v.sq[0] + v.sq[1] + v.sq[2];
         r.srem = '0;
         r.root = '0;
      end else if (k >= ST_RT0 && k < ST_RT0 + RT_N) begin
         rm = v.srem;
         rt = v.root;
         rd = v.rad;
         for (int j = 0; j < 2; j++) begin
            rm    = {rm[33:0], rd[63:62]};
            rd    = rd << 2;
            trial = {2'b00, rt, 2'b01};
            if (rm >= trial) begin
               rm = rm - trial;
               rt = {rt[30:0], 1'b1};
            end else begin
               rt = {rt[30:0], 1'b0};
            end
         end
         r.srem = rm;
         r.root = rt;
         r.rad  = rd;
      end else if (k == ST_DIV0) begin
         for (int i = 0; i < 3; i++) begin
            r.num[i]  = {v.mag[i], 16'h0000} + 48'(v.root >> 1);
            r.drem[i] = 33'(r.num[i] >> 17);
            r.quo[i]  = '0;
         end
      end else if (k >= ST_DB0 && k < ST_DB0 + DB_N) begin
         b = DB_N - 1 - (k - ST_DB0);
         for (int i = 0; i < 3; i++) begin
            tr = {v.drem[i][31:0], v.num[i][b]};
            if (tr >= {1'b0, v.root}) begin
               r.drem[i]   = tr - {1'b0, v.root};
               r.quo[i][b] = 1'b1;
            end else begin
               r.drem[i] = tr;
            end
         end
      end
      return r;
   endfunction

   pipe_type       stage_ff [NST];
   pipe_type       stage_in [NST];
   logic [NST-1:0] valid_ff;
   logic           adv;
   logic           ser_load;
   logic           ser_valid_ff;
   logic [1:0]     row_ff;
   s19_type [2:0]  s_ff;
   s24_type [2:0]  t_ff;
   s18_type [2:0]  f_ff;
   s32_type [2:0]  c3_ff;
   logic           degen_ff;

   assign ser_load  = !ser_valid_ff || (rsp_ready && (row_ff == ROW_LAST));
   assign adv       = !valid_ff[NST-1] || ser_load;
   assign req_ready = adv;

   always_comb begin
      stage_in[0]        = '0;
      stage_in[0].pos[0] = req_data.pos_x;
      stage_in[0].pos[1] = req_data.pos_y;
      stage_in[0].pos[2] = req_data.pos_z;
      stage_in[0].fv     = vec_front(req_data.fwd_x, req_data.fwd_y, req_data.fwd_z);
      stage_in[0].uv     = vec_front(req_data.up_x, req_data.up_y, req_data.up_z);
      for (int k = 1; k < NST; k++) begin
         stage_in[k]    = stage_ff[k-1];
         stage_in[k].fv = norm_next(stage_ff[k-1].fv, k);
         stage_in[k].uv = norm_next(stage_ff[k-1].uv, k);
         if (k == ST_SGN) begin
            for (int i = 0; i < 3; i++) begin
               stage_in[k].f[i] = stage_ff[k-1].fv.zero ? 18'sd0 :
                  stage_ff[k-1].fv.neg[i] ? -s18_type'({1'b0, stage_ff[k-1].fv.quo[i]}) :
                  s18_type'({1'b0, stage_ff[k-1].fv.quo[i]});
               stage_in[k].u[i] = stage_ff[k-1].uv.zero ? 18'sd0 :
                  stage_ff[k-1].uv.neg[i] ? -s18_type'({1'b0, stage_ff[k-1].uv.quo[i]}) :
                  s18_type'({1'b0, stage_ff[k-1].uv.quo[i]});
            end
            stage_in[k].degen = stage_ff[k-1].fv.zero || stage_ff[k-1].uv.zero;
         end else if (k == ST_FU) begin
            stage_in[k].pr[0] = s38_type'(stage_ff[k-1].f[1]) * s38_type'(stage_ff[k-1].u[2]);
            stage_in[k].pr[1] = s38_type'(stage_ff[k-1].f[2]) * s38_type'(stage_ff[k-1].u[1]);
            stage_in[k].pr[2] = s38_type'(stage_ff[k-1].f[2]) * s38_type'(stage_ff[k-1].u[0]);
            stage_in[k].pr[3] = s38_type'(stage_ff[k-1].f[0]) * s38_type'(stage_ff[k-1].u[2]);
            stage_in[k].pr[4] = s38_type'(stage_ff[k-1].f[0]) * s38_type'(stage_ff[k-1].u[1]);
            stage_in[k].pr[5] = s38_type'(stage_ff[k-1].f[1]) * s38_type'(stage_ff[k-1].u[0]);
         end else if (k == ST_S) begin
            for (int i = 0; i < 3; i++) begin
               stage_in[k].s[i] = s19_type'(rdiv16(64'(stage_ff[k-1].pr[2*i]) -
                                                   64'(stage_ff[k-1].pr[2*i+1])));
            end
         end else if (k == ST_SF) begin
            stage_in[k].pr[0] = s38_type'(stage_ff[k-1].s[1]) * s38_type'(stage_ff[k-1].f[2]);
            stage_in[k].pr[1] = s38_type'(stage_ff[k-1].s[2]) * s38_type'(stage_ff[k-1].f[1]);
            stage_in[k].pr[2] = s38_type'(stage_ff[k-1].s[2]) * s38_type'(stage_ff[k-1].f[0]);
            stage_in[k].pr[3] = s38_type'(stage_ff[k-1].s[0]) * s38_type'(stage_ff[k-1].f[2]);
            stage_in[k].pr[4] = s38_type'(stage_ff[k-1].s[0]) * s38_type'(stage_ff[k-1].f[1]);
            stage_in[k].pr[5] = s38_type'(stage_ff[k-1].s[1]) * s38_type'(stage_ff[k-1].f[0]);
            for (int i = 0; i < 3; i++) begin
               stage_in[k].dp[0][i] = s56_type'(stage_ff[k-1].s[i]) *
                                      s56_type'(stage_ff[k-1].pos[i]);
               stage_in[k].dp[2][i] = -(s56_type'(stage_ff[k-1].f[i]) *
                                        s56_type'(stage_ff[k-1].pos[i]));
            end
         end else if (k == ST_T) begin
            for (int i = 0; i < 3; i++) begin
               stage_in[k].t[i] = s24_type'(rdiv16(64'(stage_ff[k-1].pr[2*i]) -
                                                   64'(stage_ff[k-1].pr[2*i+1])));
            end
            stage_in[k].ds[0] = s58_type'(s56_type'(stage_ff[k-1].dp[0][0])) +
                                s58_type'(s56_type'(stage_ff[k-1].dp[0][1])) +
                                s58_type'(s56_type'(stage_ff[k-1].dp[0][2]));
            stage_in[k].ds[2] = s58_type'(s56_type'(stage_ff[k-1].dp[2][0])) +
                                s58_type'(s56_type'(stage_ff[k-1].dp[2][1])) +
                                s58_type'(s56_type'(stage_ff[k-1].dp[2][2]));
         end else if (k == ST_TP) begin
            for (int i = 0; i < 3; i++) begin
               stage_in[k].dp[1][i] = s56_type'(stage_ff[k-1].t[i]) *
                                      s56_type'(stage_ff[k-1].pos[i]);
            end
            stage_in[k].c3[0] = sat32(-rdiv16(64'(stage_ff[k-1].ds[0])));
            stage_in[k].c3[2] = sat32(-rdiv16(64'(stage_ff[k-1].ds[2])));
         end else if (k == ST_TS) begin
            stage_in[k].ds[1] = s58_type'(s56_type'(stage_ff[k-1].dp[1][0])) +
                                s58_type'(s56_type'(stage_ff[k-1].dp[1][1])) +
                                s58_type'(s56_type'(stage_ff[k-1].dp[1][2]));
         end else if (k == ST_TC) begin
            stage_in[k].c3[1] = sat32(-rdiv16(64'(stage_ff[k-1].ds[1])));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NST; k++) stage_ff[k] <= stage_in[k];
      end
      if (ser_load) begin
         s_ff     <= stage_ff[NST-1].s;
         t_ff     <= stage_ff[NST-1].t;
         f_ff     <= stage_ff[NST-1].f;
         c3_ff    <= stage_ff[NST-1].c3;
         degen_ff <= stage_ff[NST-1].degen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         ser_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else begin
         if (adv) valid_ff <= {valid_ff[NST-2:0], req_valid};
         if (ser_load) begin
            ser_valid_ff <= valid_ff[NST-1];
            row_ff       <= '0;
         end else if (rsp_ready) begin
            row_ff <= row_ff + 2'd1;
         end
      end
   end

   always_comb begin
      rsp_data            = '0;
      rsp_data.row_index  = row_ff;
      rsp_data.last_row   = (row_ff == ROW_LAST);
      rsp_data.degenerate = degen_ff;
      case (row_ff)
         2'd0: begin
            rsp_data.col0 = s32_type'(s_ff[0]);
            rsp_data.col1 = s32_type'(s_ff[1]);
            rsp_data.col2 = s32_type'(s_ff[2]);
            rsp_data.col3 = c3_ff[0];
         end
         2'd1: begin
            rsp_data.col0 = s32_type'(t_ff[0]);
            rsp_data.col1 = s32_type'(t_ff[1]);
            rsp_data.col2 = s32_type'(t_ff[2]);
            rsp_data.col3 = c3_ff[1];
         end
         2'd2: begin
            rsp_data.col0 = -s32_type'(f_ff[0]);
            rsp_data.col1 = -s32_type'(f_ff[1]);
            rsp_data.col2 = -s32_type'(f_ff[2]);
            rsp_data.col3 = c3_ff[2];
         end
         default: begin
            rsp_data.col3 = ONE_Q16;
         end
      endcase
   end

   assign rsp_valid = ser_valid_ff;

endmodule

// File: rtl/lavm_checker.sv
// port checker for the look-at view matrix unit and its bind
`timescale 1ns / 1ps
module lavm_checker
   import lavm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat withdrawn");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (rsp_data.row_index == ROW_LAST)))
      else $error("last_row out of step with row_index");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.row_index == ROW_LAST |->
         rsp_data.col0 == '0 && rsp_data.col1 == '0 && rsp_data.col2 == '0 &&
         rsp_data.col3 == ONE_Q16)
      else $error("bottom row not 0 0 0 1");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_row |=>
         rsp_valid && rsp_data.row_index == $past(rsp_data.row_index) + 2'd1 &&
         rsp_data.degenerate == $past(rsp_data.degenerate))
      else $error("matrix rows out of order");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request beat changed while waiting");

endmodule

bind look_at_view_matrix_unit lavm_checker u_lavm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/look_at_view_matrix_unit_test.sv
// testbench of the look-at view matrix unit: directed table, random beats, row predictor
`timescale 1ns / 1ps
module look_at_view_matrix_unit_test;
   import lavm_pkg::*;

   typedef enum logic [1:0] {KIND_PREDICT, KIND_ZERO, KIND_IDENT} matrix_kind_type;
   typedef struct {
      req_type         req;
      matrix_kind_type kind;
   } stim_row_type;

   localparam s32_type MAXV = 32'sh7fffffff;
   localparam s32_type MINV = 32'sh80000000;
   localparam int      N_RANDOM = 200;
   localparam int      CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type        rows_due[$];
   int             errors = 0;
   int             cycles = 0;
   bit             hold_req = 1'b0;
   bit             rush = 1'b0;
   stim_row_type   directed[14];

   look_at_view_matrix_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
      errors++;
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint round_q16(input longint v);
      longint unsigned m;
      m = v < 0 ? longint'(-v) : longint'(v);
      m = (m + 32768) >> 16;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // unit vector in q16.16; flags a zero-length input
   function automatic bit unit_vec(input s32_type a, b, c, output longint n[3]);
      longint          v[3];
      longint unsigned mag[3], mx, sum, len, q;
      v = '{a, b, c};
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = v[i] < 0 ? -v[i] : v[i];
         if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
         n = '{0, 0, 0};
         return 1'b1;
      end
      while (mx < (64'd1 << 30)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * 65536 + len / 2) / len;
         n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b0;
   endfunction

   function automatic void cross_q16(input longint a[3], input longint b[3],
                                     output longint r[3]);
      r[0] = round_q16(a[1] * b[2] - a[2] * b[1]);
      r[1] = round_q16(a[2] * b[0] - a[0] * b[2]);
      r[2] = round_q16(a[0] * b[1] - a[1] * b[0]);
   endfunction

   function automatic rsp_type make_row(input int k, input longint c[4], input bit degen);
      rsp_type r;
      r.row_index = k[1:0];
      r.col0 = c[0][31:0];
      r.col1 = c[1][31:0];
      r.col2 = c[2][31:0];
      r.col3 = c[3][31:0];
      r.last_row = (k[1:0] == ROW_LAST);
      r.degenerate = degen;
      return r;
   endfunction

   task automatic predict_view_rows(input req_type r);
      longint f[3], u[3], s[3], t[3], p[3], m[3][3], c[4], dot;
      bit     degen;
      degen = unit_vec(r.fwd_x, r.fwd_y, r.fwd_z, f);
      if (unit_vec(r.up_x, r.up_y, r.up_z, u)) degen = 1'b1;
      cross_q16(f, u, s);
      cross_q16(s, f, t);
      p = '{r.pos_x, r.pos_y, r.pos_z};
      m[0] = s;
      m[1] = t;
      m[2] = '{-f[0], -f[1], -f[2]};
      for (int k = 0; k < 3; k++) begin
         dot = 0;
         for (int i = 0; i < 3; i++) begin
            c[i] = m[k][i];
            dot += m[k][i] * p[i];
         end
         c[3] = clamp32(-round_q16(dot));
         rows_due.push_back(make_row(k, c, degen));
      end
      c = '{0, 0, 0, ONE_Q16};
      rows_due.push_back(make_row(3, c, degen));
   endtask

   task automatic queue_known(input matrix_kind_type kind);
      longint c[4];
      for (int k = 0; k < 4; k++) begin
         c = '{0, 0, 0, 0};
         if (kind == KIND_IDENT || k == 3) c[k] = ONE_Q16;
         rows_due.push_back(make_row(k, c, kind == KIND_ZERO));
      end
   endtask

   function automatic req_type mk(input s32_type px, py, pz, fx, fy, fz, ux, uy, uz);
      return '{px, py, pz, fx, fy, fz, ux, uy, uz};
   endfunction

   function automatic s32_type rand_comp();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(0, 1) ? MAXV : MINV;
         2, 3: return s32_type'($urandom_range(0, 511)) - 256;
         4: return s32_type'($urandom_range(0, 1 << 20)) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_beat(input req_type r, input matrix_kind_type kind);
      int gap;
      gap = rush ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      if (kind == KIND_PREDICT) predict_view_rows(r);
      else queue_known(kind);
   endtask

   initial begin
      directed[0]  = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), KIND_ZERO};
      directed[1]  = '{mk(MAXV, MINV, 7, 0, 0, 0, 0, ONE_Q16, 0), KIND_ZERO};
      directed[2]  = '{mk(-5, 9, MAXV, ONE_Q16, 3, -2, 0, 0, 0), KIND_PREDICT};
      directed[3]  = '{mk(0, 0, 0, 0, 0, -ONE_Q16, 0, ONE_Q16, 0), KIND_IDENT};
      directed[4]  = '{mk(0, 0, 0, 0, 0, -1, 0, 1, 0), KIND_IDENT};
      directed[5]  = '{mk(0, 0, 0, 0, 0, MINV, 0, MAXV, 0), KIND_IDENT};
      directed[6]  = '{mk(MAXV, MAXV, MAXV, ONE_Q16, ONE_Q16, ONE_Q16, 0, ONE_Q16, 0),
                       KIND_PREDICT};
      directed[7]  = '{mk(MINV, MINV, MINV, MINV, MINV, MINV, MAXV, MINV, MAXV),
                       KIND_PREDICT};
      directed[8]  = '{mk(ONE_Q16, 2, 3, ONE_Q16, 0, 0, 5 * ONE_Q16, 0, 0), KIND_PREDICT};
      directed[9]  = '{mk(MAXV, MINV, MAXV, MAXV, MAXV, MAXV, -1, 1, -1), KIND_PREDICT};
      directed[10] = '{mk(ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, -ONE_Q16, 0, 0, 0, 0, ONE_Q16),
                       KIND_PREDICT};
      directed[11] = '{mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV),
                       KIND_PREDICT};
      directed[12] = '{mk(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV),
                       KIND_PREDICT};
      directed[13] = '{mk(-1, -1, -1, 1, 0, 0, 0, -1, 0), KIND_PREDICT};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_beat(directed[i].req, directed[i].kind);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 40) hold_req = 1'b1;
         if (n == 100) begin
            req_valid <= 1'b0;
            while (rows_due.size() != 0) @(posedge clock);
         end
         rush = (n >= 130 && n < 160);
         send_beat(mk(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                      rand_comp(), rand_comp(), rand_comp(), rand_comp()), KIND_PREDICT);
      end
      req_valid <= 1'b0;

      while (rows_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && rows_due.size() == 0 && !rsp_valid)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // response side: random stalls, one long hold-off while requests keep coming
   initial begin
      rsp_type want;
      int      stall;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_req = 1'b0;
         end
         stall = rush ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (rows_due.size() == 0) begin
            report("unexpected beat row_index", rsp_data.row_index, -1);
         end else begin
            want = rows_due.pop_front();
            if (rsp_data.row_index != want.row_index)
               report("row_index", rsp_data.row_index, want.row_index);
            if (rsp_data.col0 != want.col0) report("col0", rsp_data.col0, want.col0);
            if (rsp_data.col1 != want.col1) report("col1", rsp_data.col1, want.col1);
            if (rsp_data.col2 != want.col2) report("col2", rsp_data.col2, want.col2);
            if (rsp_data.col3 != want.col3) report("col3", rsp_data.col3, want.col3);
            if (rsp_data.last_row != want.last_row)
               report("last_row", rsp_data.last_row, want.last_row);
            if (rsp_data.degenerate != want.degenerate)
               report("degenerate", rsp_data.degenerate, want.degenerate);
         end
      end
   end

endmodule
